[hdl/fhfa_pkg.sv]
// Shared types and codes for the free hole fit allocator.
package fhfa_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_ALLOC  = 1'b1;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] length;
   } hole_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_RESP
   } fsm_state_type;

endpackage

[hdl/fhfa_store.sv]
// Hole store: one write port, one read port with registered read data.
module fhfa_store
   import fhfa_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  hole_entry_type                   wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output hole_entry_type                   rd_data
);

   hole_entry_type mem [DEPTH];
   hole_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/free_hole_fit_allocator_core.sv]
// Free hole allocator: one request at a time. An allocate reads the store one hole per
// cycle through its single read port (not at all on an empty store), and an exact fit
// that removes a hole with later holes behind it then moves the tail down one place,
// again through that port.
// Holes live in a synchronous memory of MAX_HOLES entries; a scan or a tail move
// reads only entries below the current count. A finished result sits in an output
// register until it is taken; the next result waits for that register to empty.
module free_hole_fit_allocator_core
   import fhfa_pkg::*;
#(
   parameter int MAX_HOLES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_hole_offset,
   input  logic [31:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted_offset,
   output logic [31:0] rsp_granted_length,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   localparam int IW = $clog2(MAX_HOLES);
   localparam int CW = $clog2(MAX_HOLES + 1);

   fsm_state_type  state_ff, state_in;
   logic [1:0]     fit_strategy_ff;
   logic [CW-1:0]  hole_count_ff, hole_count_in;
   logic           op_ff, op_in;
   logic [31:0]    off_ff, off_in;
   logic [31:0]    need_ff, need_in;
   logic [CW-1:0]  rd_idx_ff, rd_idx_in;
   logic           chk_vld_ff, chk_vld_in;
   logic [IW-1:0]  chk_idx_ff, chk_idx_in;
   logic           pick_vld_ff, pick_vld_in;
   logic [IW-1:0]  pick_idx_ff, pick_idx_in;
   logic [31:0]    pick_off_ff, pick_off_in;
   logic [31:0]    pick_len_ff, pick_len_in;
   logic [CW-1:0]  sh_rd_ff, sh_rd_in;
   logic           sh_vld_ff, sh_vld_in;
   logic [IW-1:0]  sh_wr_ff, sh_wr_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [31:0]    res_off_ff, res_off_in;
   logic [31:0]    res_len_ff, res_len_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_off_ff, rsp_off_in;
   logic [31:0]    rsp_len_ff, rsp_len_in;

   logic           mem_wr_en;
   logic [IW-1:0]  mem_wr_addr;
   hole_entry_type mem_wr_data;
   logic [IW-1:0]  mem_rd_addr;
   hole_entry_type mem_rd_data;

   logic [CW-1:0]  sh_prev;
   logic [CW-1:0]  pick_next;
   logic [CW-1:0]  count_last;
   logic           fits;
   logic           better;

   fhfa_store #(
      .DEPTH (MAX_HOLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign sh_prev    = sh_rd_ff - CW'(1);
   assign pick_next  = CW'(pick_idx_ff) + CW'(1);
   assign count_last = hole_count_ff - CW'(1);

   assign fits   = mem_rd_data.length >= need_ff;
   assign better = !pick_vld_ff
                || (fit_strategy_ff == FIT_BEST  && mem_rd_data.length < pick_len_ff)
                || (fit_strategy_ff == FIT_WORST && mem_rd_data.length > pick_len_ff);

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_off_ff;
   assign rsp_granted_length = rsp_len_ff;

   always_comb begin
      state_in      = state_ff;
      hole_count_in = hole_count_ff;
      op_in         = op_ff;
      off_in        = off_ff;
      need_in       = need_ff;
      rd_idx_in     = rd_idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      pick_vld_in   = pick_vld_ff;
      pick_idx_in   = pick_idx_ff;
      pick_off_in   = pick_off_ff;
      pick_len_in   = pick_len_ff;
      sh_rd_in      = sh_rd_ff;
      sh_vld_in     = 1'b0;
      sh_wr_in      = sh_wr_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      res_len_in    = res_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_len_in    = rsp_len_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = mem_rd_data;
      mem_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_operation;
               off_in      = req_hole_offset;
               need_in     = req_length;
               rd_idx_in   = '0;
               pick_vld_in = 1'b0;
               if (req_operation == OP_INSERT) begin
                  state_in = ST_INSERT;
               end else if (hole_count_ff == '0) begin
                  res_status_in = STATUS_NO_FIT;
                  res_off_in    = '0;
                  res_len_in    = '0;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_INSERT: begin
            res_off_in = '0;
            res_len_in = '0;
            if (hole_count_ff == CW'(MAX_HOLES)) begin
               res_status_in = STATUS_FULL;
            end else begin
               res_status_in      = STATUS_DONE;
               mem_wr_en          = 1'b1;
               mem_wr_addr        = hole_count_ff[IW-1:0];
               mem_wr_data.offset = off_ff;
               mem_wr_data.length = need_ff;
               hole_count_in      = hole_count_ff + CW'(1);
            end
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            // issue one read per cycle; data comes back tagged in the next cycle
            if (rd_idx_ff < hole_count_ff) begin
               mem_rd_addr = rd_idx_ff[IW-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = rd_idx_ff[IW-1:0];
               rd_idx_in   = rd_idx_ff + CW'(1);
            end
            if (chk_vld_ff) begin
               if (fits && better) begin
                  pick_vld_in = 1'b1;
                  pick_idx_in = chk_idx_ff;
                  pick_off_in = mem_rd_data.offset;
                  pick_len_in = mem_rd_data.length;
               end
               if (CW'(chk_idx_ff) == count_last) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (!pick_vld_ff) begin
               res_status_in = STATUS_NO_FIT;
               res_off_in    = '0;
               res_len_in    = '0;
               state_in      = ST_RESP;
            end else begin
               res_status_in = STATUS_DONE;
               res_off_in    = pick_off_ff;
               res_len_in    = need_ff;
               if (pick_len_ff == need_ff) begin
                  if (pick_next < hole_count_ff) begin
                     sh_rd_in = pick_next;
                     state_in = ST_SHIFT;
                  end else begin
                     hole_count_in = count_last;
                     state_in      = ST_RESP;
                  end
               end else begin
                  mem_wr_en          = 1'b1;
                  mem_wr_addr        = pick_idx_ff;
                  mem_wr_data.offset = pick_off_ff + need_ff;
                  mem_wr_data.length = pick_len_ff - need_ff;
                  state_in           = ST_RESP;
               end
            end
         end
         ST_SHIFT: begin
            // read entry j while entry j-1 moves down into j-2: never the same entry
            if (sh_rd_ff < hole_count_ff) begin
               mem_rd_addr = sh_rd_ff[IW-1:0];
               sh_vld_in   = 1'b1;
               sh_wr_in    = sh_prev[IW-1:0];
               sh_rd_in    = sh_rd_ff + CW'(1);
            end
            if (sh_vld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = sh_wr_ff;
               mem_wr_data = mem_rd_data;
            end
            if (sh_rd_ff == hole_count_ff) begin
               hole_count_in = count_last;
               state_in      = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               rsp_len_in    = res_len_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fit_strategy_ff <= FIT_FIRST;
         hole_count_ff   <= '0;
         chk_vld_ff      <= 1'b0;
         pick_vld_ff     <= 1'b0;
         sh_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hole_count_ff <= hole_count_in;
         chk_vld_ff    <= chk_vld_in;
         pick_vld_ff   <= pick_vld_in;
         sh_vld_ff     <= sh_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            fit_strategy_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      off_ff        <= off_in;
      need_ff       <= need_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      pick_idx_ff   <= pick_idx_in;
      pick_off_ff   <= pick_off_in;
      pick_len_ff   <= pick_len_in;
      sh_rd_ff      <= sh_rd_in;
      sh_wr_ff      <= sh_wr_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // only allocates walk the store
   a_scan_is_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SHIFT) |-> op_ff == OP_ALLOC)
      else $error("store walk during an insert");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      hole_count_ff <= CW'(MAX_HOLES))
      else $error("hole count above capacity");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && pick_vld_ff) |-> pick_len_ff >= need_ff)
      else $error("picked hole is smaller than the request");

   a_no_fit_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && !pick_vld_ff) |=> $stable(hole_count_ff))
      else $error("failed allocate changed the hole count");

   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && sh_vld_ff && sh_rd_ff < hole_count_ff)
         |-> mem_wr_addr != mem_rd_addr)
      else $error("tail move reads and writes the same entry");

endmodule

[bench/tb.sv]
// Self-checking testbench for the free hole fit allocator core.
module tb;
   import fhfa_pkg::*;

   localparam int MAX_HOLES = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [1:0] FIT_SPARE = 2'd3;   // unused code, behaves as first fit

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] offset;
      logic [31:0] length;
   } grant_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_INSERT;
   logic [31:0] req_hole_offset = '0;
   logic [31:0] req_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_granted_offset;
   logic [31:0] rsp_granted_length;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = FIT_FIRST;

   // mirror of the hole store and the strategy register
   logic [31:0] free_off [MAX_HOLES];
   logic [31:0] free_len [MAX_HOLES];
   int          free_count = 0;
   logic [1:0]  fit_mode = FIT_FIRST;

   grant_type   pending_grants [$];
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          errors = 0;
   int          n_checked = 0;
   int          n_inserts = 0;
   int          n_allocs = 0;
   int          n_full = 0;
   int          n_nofit = 0;
   int          cycle_count = 0;

   free_hole_fit_allocator_core #(.MAX_HOLES(MAX_HOLES)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_hole_offset    (req_hole_offset),
      .req_length         (req_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_granted_length (rsp_granted_length),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("free_hole_fit_allocator_core test failed");
         $finish;
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // Index of the hole the current strategy picks, -1 when nothing is long enough.
   function automatic int pick_hole(logic [31:0] need);
      int chosen;
      chosen = -1;
      for (int i = 0; i < free_count; i++) begin
         if (free_len[i] >= need) begin
            if (chosen < 0) begin
               chosen = i;
               if (fit_mode != FIT_BEST && fit_mode != FIT_WORST) break;
            end else if (fit_mode == FIT_BEST && free_len[i] < free_len[chosen]) begin
               chosen = i;
            end else if (fit_mode == FIT_WORST && free_len[i] > free_len[chosen]) begin
               chosen = i;
            end
         end
      end
      return chosen;
   endfunction

   function automatic grant_type predict_grant(logic op, logic [31:0] off, logic [31:0] len);
      grant_type g;
      int k;
      g = '0;
      g.status = STATUS_DONE;
      if (op == OP_INSERT) begin
         n_inserts++;
         if (free_count >= MAX_HOLES) begin
            g.status = STATUS_FULL;
            n_full++;
         end else begin
            free_off[free_count] = off;
            free_len[free_count] = len;
            free_count++;
         end
      end else begin
         n_allocs++;
         k = pick_hole(len);
         if (k < 0) begin
            g.status = STATUS_NO_FIT;
            n_nofit++;
         end else begin
            g.offset = free_off[k];
            g.length = len;
            if (free_len[k] == len) begin
               // exact fit: close the gap, later holes keep their order
               for (int i = k; i + 1 < free_count; i++) begin
                  free_off[i] = free_off[i + 1];
                  free_len[i] = free_len[i + 1];
               end
               free_count--;
            end else begin
               free_off[k] = free_off[k] + len;
               free_len[k] = free_len[k] - len;
            end
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin : check_grants
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $error("result with nothing pending: status %0d offset %h length %h",
                   rsp_status, rsp_granted_offset, rsp_granted_length);
            errors++;
         end else begin
            want = pending_grants.pop_front();
            n_checked++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_granted_offset !== want.offset) begin
               $error("granted_offset: expected %h, got %h", want.offset, rsp_granted_offset);
               errors++;
            end
            if (rsp_granted_length !== want.length) begin
               $error("granted_length: expected %h, got %h", want.length, rsp_granted_length);
               errors++;
            end
         end
      end
   end

   task automatic send_request(input logic op, input logic [31:0] off, input logic [31:0] len);
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_hole_offset <= off;
      req_length      <= len;
      do @(posedge clock); while (!req_ready);
      pending_grants.push_back(predict_grant(op, off, len));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   task automatic write_fit_mode(input logic [1:0] mode);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fit_mode = mode;
   endtask

   task automatic test_empty_store();
      write_fit_mode(FIT_FIRST);
      send_request(OP_ALLOC, 32'h0, 32'h0);
   endtask

   // Sixteen holes with ties, a zero-length hole and an all-ones hole near the top,
   // then one more insert that must be dropped.
   task automatic test_fill_to_capacity();
      logic [31:0] off;
      send_request(OP_INSERT, 32'h0000_0100, 32'd8);
      send_request(OP_INSERT, 32'h0000_0200, 32'd0);
      send_request(OP_INSERT, 32'h0000_0300, 32'd4);
      send_request(OP_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0400, 32'd4);
      for (int i = 5; i < MAX_HOLES; i++) begin
         off = (i == 5) ? 32'h0 : (i == 6) ? 32'hFFFF_FFFF : 32'(i) << 12;
         send_request(OP_INSERT, off, 32'(20 + i % 3));
      end
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_first_fit_split();
      write_fit_mode(FIT_FIRST);
      send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd3);
   endtask

   task automatic test_best_fit_ties();
      write_fit_mode(FIT_BEST);
      send_request(OP_ALLOC, 32'h0, 32'd4);   // two holes of 4, earlier one goes
      send_request(OP_ALLOC, 32'h0, 32'd0);   // zero-length hole removed
   endtask

   task automatic test_worst_fit_wrap();
      write_fit_mode(FIT_WORST);
      send_request(OP_ALLOC, 32'h0, 32'h20);  // shrunk offset wraps past the top
   endtask

   task automatic test_spare_mode();
      write_fit_mode(FIT_SPARE);
      send_request(OP_ALLOC, 32'h0, 32'd0);   // longer hole left as is
      send_request(OP_ALLOC, 32'h0, 32'd5);   // exact fit at the head
   endtask

   task automatic test_no_fit();
      write_fit_mode(FIT_WORST);
      send_request(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_items);
      int          ins_pct;
      logic        op;
      logic [31:0] off;
      logic [31:0] len;
      logic [31:0] longest;
      ins_pct = 50;
      req_gap_pct   <= gap_pct;
      rsp_stall_pct <= stall_pct;
      for (int n = 0; n < n_items; n++) begin
         if (n % 150 == 0) write_fit_mode(2'((n / 150) % 4));
         // swing between filling and draining so the store hits both ends
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0:       ins_pct = 20;
               1:       ins_pct = 50;
               default: ins_pct = 80;
            endcase
         end
         op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_ALLOC;
         off = $urandom;
         if (op == OP_INSERT) begin
            if ($urandom_range(9) == 0) off = 32'hFFFF_FFFF - $urandom_range(63);
            case ($urandom_range(9))
               0, 1, 2, 3, 4: len = $urandom_range(16);
               5, 6:          len = $urandom_range(255);
               7:             len = 32'hFFFF_FFFF - $urandom_range(3);
               default:       len = $urandom;
            endcase
         end else begin
            longest = '0;
            for (int i = 0; i < free_count; i++)
               if (free_len[i] > longest) longest = free_len[i];
            case ($urandom_range(9))
               0, 1, 2: len = (free_count > 0) ? free_len[$urandom_range(free_count - 1)]
                                               : 32'($urandom_range(8));
               3, 4, 5: len = $urandom_range(8);
               6:       len = 32'h0;
               7:       len = longest + 32'd1;
               default: len = $urandom;
            endcase
         end
         send_request(op, off, len);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      req_gap_pct   <= 16;
      rsp_stall_pct <= 73;
      test_empty_store();
      test_fill_to_capacity();
      test_first_fit_split();
      test_best_fit_ties();
      test_worst_fit_wrap();
      test_spare_mode();
      test_no_fit();
      test_random_traffic(16, 73, 600);
      test_random_traffic(73, 16, 600);
      test_random_traffic(0, 0, 600);
      wait_idle();
      repeat (40) @(posedge clock);
      $display("Checked %0d results: %0d inserts, %0d allocates, fit codes 0 to 3,",
               n_checked, n_inserts, n_allocs);
      $display("%0d no-fit and %0d full-store outcomes, three pacing mixes.", n_nofit, n_full);
      if (errors == 0) begin
         $display("free_hole_fit_allocator_core test passed");
      end else begin
         $display("free_hole_fit_allocator_core test failed");
      end
      $finish;
   end

endmodule
